// ----- design/bounded_queue_with_positional_insert_macros.svh -----
// assertion macros for the bounded queue checker
`ifndef BOUNDED_QUEUE_WITH_POSITIONAL_INSERT_MACROS_SVH
`define BOUNDED_QUEUE_WITH_POSITIONAL_INSERT_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define BQI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define BQI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/bqi_pkg.sv -----
// shared constants, request codes and index helpers for the bounded queue
package bqi_pkg;

    localparam int QUEUE_DEPTH = 16;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = PTR_W + 2;
    localparam int POS_W  = 5;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int DATA_W = 32;
    localparam int WORD_W = 2 * DATA_W;

    typedef logic [PTR_W-1:0]  t_ptr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [WORD_W-1:0] t_word;

    localparam logic [1:0] REQ_ENQ = 2'd0;
    localparam logic [1:0] REQ_DEQ = 2'd1;
    localparam logic [1:0] REQ_INS = 2'd2;
    localparam logic [1:0] REQ_CLR = 2'd3;

    // logical slot (below the depth) to physical slot of the ring
    function automatic t_ptr phys_slot(input t_ptr head, input t_cnt lg);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(lg);
        if (sum >= SUM_W'(QUEUE_DEPTH)) begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
        end
        return PTR_W'(sum);
    endfunction

    function automatic t_ptr ptr_inc(input t_ptr p);
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

endpackage

// ----- design/bounded_queue_with_positional_insert.sv -----
// bounded queue with positional insert, ring buffer in one synchronous ram
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  -------------------------------------
//  in        to block   i_in_valid / o_in_ready   req_type, in_arrive, in_service_time,
//                                                 position
//  out       from block o_out_valid / i_out_ready ok, out_arrive, out_service_time,
//                                                 count, empty_res, full_res
//
// enqueue, clear, insert at the tail and every failed request: result loaded from idle
// dequeue: head read from the ram, then loaded into the result register from ST_DEQ
// insert at p: the entries from p upward move back one slot, one entry moved per
//   cycle through the single read and single write port of the ram
// reset clears the count, the head pointer and the control state; ram contents stay
// an item is taken only while the sequencer is idle and the result register is free
//   or being emptied in the same cycle; a stalled result holds off new items
module bounded_queue_with_positional_insert (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_req_type,
    input  logic [bqi_pkg::DATA_W-1:0] i_in_arrive,
    input  logic [bqi_pkg::DATA_W-1:0] i_in_service_time,
    input  logic [bqi_pkg::POS_W-1:0]  i_position,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_ok,
    output logic [bqi_pkg::DATA_W-1:0] o_out_arrive,
    output logic [bqi_pkg::DATA_W-1:0] o_out_service_time,
    output logic [bqi_pkg::POS_W-1:0]  o_count,
    output logic                       o_empty_res,
    output logic                       o_full_res
);
    import bqi_pkg::*;

    // sequencer codes
    localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for an item
    localparam logic [2:0] ST_DEQ   = 3'd1;  // head read in flight
    localparam logic [2:0] ST_SHIFT = 3'd2;  // moving entries back one slot
    localparam logic [2:0] ST_DRAIN = 3'd3;  // last moved entry written
    localparam logic [2:0] ST_FIN   = 3'd4;  // new item written at its slot

    // ring storage, one write and one read port, registered read data
    t_word r_mem [QUEUE_DEPTH];
    t_word r_rd_data;

    logic  mem_we;
    t_ptr  mem_waddr;
    t_word mem_wdata;
    t_ptr  mem_raddr;

    // control state
    logic [2:0] r_state, n_state;
    t_ptr       r_head, n_head;
    t_cnt       r_count, n_count;
    t_cnt       r_idx, n_idx;        // logical slot that receives the next moved entry
    t_cnt       r_wr_idx, n_wr_idx;  // destination of the entry now in r_rd_data
    logic       r_wr_pend, n_wr_pend;
    t_cnt       r_pos, n_pos;        // logical slot of the inserted item
    t_word      r_word, n_word;

    // result register
    logic                r_out_valid;
    logic                r_ok;
    logic [DATA_W-1:0]   r_out_arrive;
    logic [DATA_W-1:0]   r_out_svc;
    t_cnt                r_out_count;

    logic                out_load;
    logic                ld_ok;
    logic [DATA_W-1:0]   ld_arrive;
    logic [DATA_W-1:0]   ld_svc;
    t_cnt                ld_count;

    logic acc;
    logic out_taken;
    logic is_full;
    logic past_end;
    t_cnt ins_pos;
    t_cnt idx_dec;

    // a waiting result blocks new items unless it leaves this cycle
    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign acc        = i_in_valid && o_in_ready;
    assign out_taken  = r_out_valid && i_out_ready;

    assign is_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    // insert position is clamped to the count, so far positions append
    assign past_end = (CMP_W'(i_position) > CMP_W'(r_count));
    assign ins_pos  = past_end ? r_count : CNT_W'(i_position);
    assign idx_dec  = r_idx - CNT_W'(1);

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_idx     = r_idx;
        n_wr_idx  = r_wr_idx;
        n_wr_pend = r_wr_pend;
        n_pos     = r_pos;
        n_word    = r_word;

        mem_we    = 1'b0;
        mem_waddr = phys_slot(r_head, r_count);
        mem_wdata = r_word;
        mem_raddr = r_head;

        out_load  = 1'b0;
        ld_ok     = 1'b0;
        ld_arrive = '0;
        ld_svc    = '0;
        ld_count  = r_count;

        unique case (r_state)
            ST_IDLE: begin
                if (acc) begin
                    out_load = 1'b1;
                    unique case (i_req_type)
                        REQ_ENQ: begin
                            if (!is_full) begin
                                mem_we    = 1'b1;
                                mem_wdata = {i_in_arrive, i_in_service_time};
                                n_count   = r_count + CNT_W'(1);
                                ld_ok     = 1'b1;
                                ld_count  = n_count;
                            end
                        end
                        REQ_DEQ: begin
                            if (r_count != '0) begin
                                // read the head now, load it into the result register from ST_DEQ
                                out_load = 1'b0;
                                n_head   = ptr_inc(r_head);
                                n_count  = r_count - CNT_W'(1);
                                n_state  = ST_DEQ;
                            end
                        end
                        REQ_INS: begin
                            if (!is_full) begin
                                if (ins_pos == r_count) begin
                                    // insert at the tail is a plain enqueue
                                    mem_we    = 1'b1;
                                    mem_wdata = {i_in_arrive, i_in_service_time};
                                    n_count   = r_count + CNT_W'(1);
                                    ld_ok     = 1'b1;
                                    ld_count  = n_count;
                                end else begin
                                    out_load = 1'b0;
                                    n_word   = {i_in_arrive, i_in_service_time};
                                    n_pos    = ins_pos;
                                    n_idx    = r_count;
                                    n_state  = ST_SHIFT;
                                end
                            end
                        end
                        REQ_CLR: begin
                            n_count  = '0;
                            n_head   = '0;
                            ld_ok    = 1'b1;
                            ld_count = '0;
                        end
                    endcase
                end
            end
            ST_DEQ: begin
                out_load  = 1'b1;
                ld_ok     = 1'b1;
                ld_arrive = r_rd_data[WORD_W-1:DATA_W];
                ld_svc    = r_rd_data[DATA_W-1:0];
                ld_count  = r_count;
                n_state   = ST_IDLE;
            end
            ST_SHIFT: begin
                // read slot idx-1 while the previous read lands two slots higher
                mem_raddr = phys_slot(r_head, idx_dec);
                if (r_wr_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = phys_slot(r_head, r_wr_idx);
                    mem_wdata = r_rd_data;
                end
                n_wr_idx  = r_idx;
                n_wr_pend = 1'b1;
                n_idx     = idx_dec;
                if (idx_dec == r_pos) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                mem_we    = 1'b1;
                mem_waddr = phys_slot(r_head, r_wr_idx);
                mem_wdata = r_rd_data;
                n_wr_pend = 1'b0;
                n_state   = ST_FIN;
            end
            ST_FIN: begin
                mem_we    = 1'b1;
                mem_waddr = phys_slot(r_head, r_pos);
                mem_wdata = r_word;
                n_count   = r_count + CNT_W'(1);
                out_load  = 1'b1;
                ld_ok     = 1'b1;
                ld_count  = n_count;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state   = ST_IDLE;
                n_wr_pend = 1'b0;
            end
        endcase
    end

    // ram write port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    // ram read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[mem_raddr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_wr_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_wr_pend <= n_wr_pend;
        end
    end

    // insert bookkeeping, meaningful only inside an insert
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_wr_idx <= n_wr_idx;
        r_pos    <= n_pos;
        r_word   <= n_word;
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (out_taken) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_ok         <= ld_ok;
            r_out_arrive <= ld_arrive;
            r_out_svc    <= ld_svc;
            r_out_count  <= ld_count;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_ok               = r_ok;
    assign o_out_arrive       = r_out_arrive;
    assign o_out_service_time = r_out_svc;
    assign o_count            = POS_W'(r_out_count);
    assign o_empty_res        = (r_out_count == '0);
    assign o_full_res         = (r_out_count == CNT_W'(QUEUE_DEPTH));

endmodule

// ----- design/bqi_checker.sv -----
// port-level checker for the bounded queue, bound to the top level
`include "bounded_queue_with_positional_insert_macros.svh"

module bqi_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic [1:0]                 i_req_type,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic                       o_ok,
    input logic [bqi_pkg::DATA_W-1:0] o_out_arrive,
    input logic [bqi_pkg::DATA_W-1:0] o_out_service_time,
    input logic [bqi_pkg::POS_W-1:0]  o_count
);
    import bqi_pkg::*;

    logic in_acc;
    logic out_stall;
    logic clr_ok;
    logic zero_data;

    assign in_acc    = i_in_valid && o_in_ready;
    assign out_stall = o_out_valid && !i_out_ready;
    assign clr_ok    = o_out_valid && o_ok && (o_count == '0);
    assign zero_data = (o_out_arrive == '0) && (o_out_service_time == '0);

    // a result waits until it is taken
    `BQI_ASSERT_NEXT(a_out_hold, out_stall, o_out_valid, "result dropped while stalled")

    // a stalled result holds off new items
    `BQI_ASSERT_NOW(a_stall_blocks_in, out_stall, !o_in_ready, "item taken while stalled")

    // clear reports success and an empty queue in the next cycle
    `BQI_ASSERT_NEXT(a_clear_result, in_acc && i_req_type == REQ_CLR, clr_ok, "clear result wrong")

    // an accepted enqueue has its result valid in the next cycle
    `BQI_ASSERT_NEXT(a_enq_one_cycle, in_acc && i_req_type == REQ_ENQ, o_out_valid, "enqueue late")

    // only a successful dequeue carries item data
    `BQI_ASSERT_NOW(a_fail_zero_data, o_out_valid && !o_ok, zero_data, "failed result has data")

endmodule

bind bounded_queue_with_positional_insert bqi_checker u_bqi_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_ready         (o_in_ready),
    .i_req_type         (i_req_type),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_ok               (o_ok),
    .o_out_arrive       (o_out_arrive),
    .o_out_service_time (o_out_service_time),
    .o_count            (o_count)
);
